// ----- sv/ubds_pkg.sv -----
// Shared constants and types for the baud divisor search.
package ubds_pkg;

  localparam int CLK_W     = 32;
  localparam int BAUD_W    = 24;
  localparam int DIV_W     = 16;
  localparam int RATIO_MIN = 4;
  localparam int RATIO_MAX = 32;
  localparam int NRATIO    = RATIO_MAX - RATIO_MIN + 1;
  // One cell per quotient bit in each of the two dividers, plus three registers.
  localparam int LANE_LAT  = 2 * CLK_W + 3;

  localparam logic [CLK_W-1:0] CLK_RESET  = 32'd48000000;
  localparam logic [4:0]       NONE_FIELD = 5'd15;
  localparam logic [CLK_W-1:0] NONE_ERROR = 32'hFFFF_FFFF;

  // Partial division state handed from one divider cell to the next.
  typedef struct packed {
    logic [CLK_W-1:0] rem;
    logic [CLK_W-1:0] quo;
    logic [CLK_W-1:0] den;
  } div_t;

  // Result of one ratio lane.
  typedef struct packed {
    logic             ok;
    logic [DIV_W-1:0] dv;
    logic [CLK_W-1:0] err;
  } cand_t;

  // Running best choice along the pick chain.
  typedef struct packed {
    logic             vld;
    logic             found;
    logic [DIV_W-1:0] dv;
    logic [4:0]       field;
    logic [CLK_W-1:0] err;
  } best_t;

endpackage

// ----- sv/ubds_ifs.sv -----
// Channel interfaces for request, result and clock configuration items.
interface ubds_req_if;
  logic                         valid;
  logic                         ready;
  logic [ubds_pkg::BAUD_W-1:0] requested_baud;
  modport source (output valid, output requested_baud, input ready);
  modport sink (input valid, input requested_baud, output ready);
endinterface

interface ubds_res_if;
  logic        valid;
  logic        ready;
  logic [12:0] divisor;
  logic [4:0]  oversample_field;
  logic        found;
  logic [31:0] baud_error;
  modport source (output valid, output divisor, output oversample_field, output found,
                  output baud_error, input ready);
  modport sink (input valid, input divisor, input oversample_field, input found,
                input baud_error, output ready);
endinterface

interface ubds_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_clock_hz;
  modport source (output valid, output source_clock_hz, input ready);
  modport sink (input valid, input source_clock_hz, output ready);
endinterface

// ----- sv/ubds_div_cell.sv -----
// One restoring division step: takes a dividend bit, yields one quotient bit.
module ubds_div_cell #(
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                en,
  input  logic                num_bit,
  input  ubds_pkg::div_t      d_in,
  input  logic [SIDE_W-1:0]   side_in,
  output ubds_pkg::div_t      d_out,
  output logic [SIDE_W-1:0]   side_out
);

  logic [ubds_pkg::CLK_W:0] trial;
  logic [ubds_pkg::CLK_W:0] diff;
  logic                     ge;

  // Shift in the next dividend bit and try subtracting the divisor
  always_comb begin
    trial = {d_in.rem, num_bit};
    diff  = trial - {1'b0, d_in.den};
    ge    = (trial >= {1'b0, d_in.den});
  end

  // Advance the partial result
  always_ff @(posedge clk) begin
    if (en) begin
      d_out.rem <= ge ? diff[ubds_pkg::CLK_W-1:0] : trial[ubds_pkg::CLK_W-1:0];
      d_out.quo <= {d_in.quo[ubds_pkg::CLK_W-2:0], ge};
      d_out.den <= d_in.den;
      side_out  <= side_in;
    end
  end

endmodule

// ----- sv/ubds_lane.sv -----
// One ratio lane: divisor, achieved baud and error for a fixed oversampling ratio.
module ubds_lane #(
  parameter int RATIO   = 16,
  parameter int DIV_MAX = 8191
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ubds_pkg::CLK_W-1:0]   src_clk,
  input  logic [ubds_pkg::BAUD_W-1:0]  baud,
  output ubds_pkg::cand_t              cand
);

  localparam int CW  = ubds_pkg::CLK_W;
  localparam int BW  = ubds_pkg::BAUD_W;
  localparam int DW  = ubds_pkg::DIV_W;
  localparam int S2W = BW + DW + 1;

  ubds_pkg::div_t  st1 [0:CW];
  logic [BW-1:0]   sd1 [0:CW];
  ubds_pkg::div_t  st2 [0:CW];
  logic [S2W-1:0]  sd2 [0:CW];

  logic [CW-1:0]   q1;
  logic            ok1;
  logic [DW-1:0]   dv1;
  logic [CW-1:0]   den2;
  logic [CW-1:0]   q2;
  logic [CW-1:0]   b2;

  // Form baud times ratio as the first divisor
  always_ff @(posedge clk) begin
    if (en) begin
      st1[0].rem <= '0;
      st1[0].quo <= '0;
      st1[0].den <= CW'(baud) * CW'(RATIO);
      sd1[0]     <= baud;
    end
  end

  genvar i;
  generate
    for (i = 0; i < CW; i++) begin : g_div1
      ubds_div_cell #(.SIDE_W(BW)) u_cell (
        .clk(clk), .en(en), .num_bit(src_clk[CW-1-i]),
        .d_in(st1[i]), .side_in(sd1[i]), .d_out(st1[i+1]), .side_out(sd1[i+1])
      );
    end
  endgenerate

  // Check the divisor range and form ratio times divisor
  always_comb begin
    q1   = st1[CW].quo;
    ok1  = (sd1[CW] != '0) && (q1 != '0) && (q1 <= CW'(DIV_MAX));
    dv1  = q1[DW-1:0];
    den2 = ok1 ? CW'(RATIO) * CW'(dv1) : CW'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st2[0].rem <= '0;
      st2[0].quo <= '0;
      st2[0].den <= den2;
      sd2[0]     <= {sd1[CW], dv1, ok1};
    end
  end

  generate
    for (i = 0; i < CW; i++) begin : g_div2
      ubds_div_cell #(.SIDE_W(S2W)) u_cell (
        .clk(clk), .en(en), .num_bit(src_clk[CW-1-i]),
        .d_in(st2[i]), .side_in(sd2[i]), .d_out(st2[i+1]), .side_out(sd2[i+1])
      );
    end
  endgenerate

  // Take the absolute error of the achieved baud
  always_comb begin
    q2 = st2[CW].quo;
    b2 = CW'(sd2[CW][S2W-1:DW+1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cand.ok  <= sd2[CW][0];
      cand.dv  <= sd2[CW][DW:1];
      cand.err <= (q2 >= b2) ? (q2 - b2) : (b2 - q2);
    end
  end

endmodule

// ----- sv/ubds_pick_cell.sv -----
// One pick cell: weighs one ratio against the best so far and hands on the rest.
module ubds_pick_cell #(
  parameter int K = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  ubds_pkg::best_t  b_in,
  input  ubds_pkg::cand_t  c_in  [ubds_pkg::NRATIO],
  output ubds_pkg::best_t  b_out,
  output ubds_pkg::cand_t  c_out [ubds_pkg::NRATIO]
);

  logic take;

  // Strictly smaller error wins, so the lower ratio keeps a tie
  always_comb begin
    take = c_in[K].ok && (c_in[K].err < b_in.err);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_out.vld <= 1'b0;
    end else if (en) begin
      b_out.vld <= b_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_out.found <= take ? 1'b1 : b_in.found;
      b_out.dv    <= take ? c_in[K].dv : b_in.dv;
      b_out.field <= take ? 5'(K + ubds_pkg::RATIO_MIN - 1) : b_in.field;
      b_out.err   <= take ? c_in[K].err : b_in.err;
      c_out       <= c_in;
    end
  end

endmodule

// ----- sv/uart_baud_divisor_search.sv -----
// Top level of the baud divisor search: ratio lanes, pick chain and output register.
//
// Usage:
//   cfg carries source_clock_hz and is always ready; the user must write it
//   only while the block is idle, as the block itself does not enforce this. req
//   carries requested_baud items, res carries the divisor, oversample_field,
//   found and baud_error of each item in order. For each request all ratios
//   4..32 are tried in parallel lanes. Each lane runs two restoring dividers
//   of 32 one-bit cells each; a chain of 29 pick cells then selects the best
//   ratio, one ratio per cell, and a final output register holds the result.
//   Throughput: one item per cycle while the pipeline is not stalled, set by
//   the one-bit-per-cell divider chains.
//   Reset: all in-flight items are dropped and source_clock_hz returns to
//   48000000.
//   Stall: when res is not taken, the result stays in the output register and
//   the pipeline keeps advancing until a finished item reaches the end of the
//   chain; only then does req drop ready.
module uart_baud_divisor_search #(
  parameter int DIVISOR_MAX = 8191
) (
  input  logic              clk,
  input  logic              rst,
  ubds_cfg_if.sink          cfg,
  ubds_req_if.sink          req,
  ubds_res_if.source        res
);

  localparam int NR = ubds_pkg::NRATIO;
  localparam int LL = ubds_pkg::LANE_LAT;

  logic [ubds_pkg::CLK_W-1:0] src_clk;
  logic                       en;
  logic [LL-1:0]              vld;
  ubds_pkg::cand_t            lane_c [NR];
  ubds_pkg::best_t            bst [0:NR];
  ubds_pkg::cand_t            cnd [0:NR][NR];

  // Hold the source clock register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      src_clk <= ubds_pkg::CLK_RESET;
    end else if (cfg.valid) begin
      src_clk <= cfg.source_clock_hz;
    end
  end

  // Advance unless a finished item is blocked by a waiting result
  assign en        = !(bst[NR].vld && res.valid && !res.ready);
  assign req.ready = en;

  // Track which lane stages hold an item
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LL-2:0], req.valid};
    end
  end

  genvar r;
  generate
    for (r = 0; r < NR; r++) begin : g_lane
      ubds_lane #(.RATIO(r + ubds_pkg::RATIO_MIN), .DIV_MAX(DIVISOR_MAX)) u_lane (
        .clk(clk), .en(en), .src_clk(src_clk), .baud(req.requested_baud),
        .cand(lane_c[r])
      );
    end
  endgenerate

  // Seed the pick chain with the no-choice result
  always_comb begin
    bst[0].vld   = vld[LL-1];
    bst[0].found = 1'b0;
    bst[0].dv    = '0;
    bst[0].field = ubds_pkg::NONE_FIELD;
    bst[0].err   = ubds_pkg::NONE_ERROR;
    cnd[0]       = lane_c;
  end

  generate
    for (r = 0; r < NR; r++) begin : g_pick
      ubds_pick_cell #(.K(r)) u_pick (
        .clk(clk), .rst(rst), .en(en), .b_in(bst[r]), .c_in(cnd[r]),
        .b_out(bst[r+1]), .c_out(cnd[r+1])
      );
    end
  endgenerate

  // Load the output register when it is empty or being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (!res.valid || res.ready) begin
      res.valid <= bst[NR].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!res.valid || res.ready) begin
      res.divisor          <= bst[NR].dv[12:0];
      res.oversample_field <= bst[NR].field;
      res.found            <= bst[NR].found;
      res.baud_error       <= bst[NR].err;
    end
  end

`ifndef NO_ASSERTIONS
  a_none_fields: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.found) |->
      (res.divisor == '0 && res.oversample_field == ubds_pkg::NONE_FIELD &&
       res.baud_error == ubds_pkg::NONE_ERROR))
    else $error("no-choice result carries wrong fields");
  a_found_ratio: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.found) |-> (res.oversample_field >= 5'd3))
    else $error("found result has ratio below minimum");
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (res.valid && !res.ready && bst[NR].vld))
    else $error("request stalled without a blocked result");
  a_chain_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("lane valid line moved during a stall");
`endif

endmodule

// ----- dv/uart_baud_divisor_search_tb.sv -----
// Testbench for the baud divisor search: directed and random requests against a predictor.
module uart_baud_divisor_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [12:0] divisor;
    logic [4:0]  oversample_field;
    logic        found;
    logic [31:0] baud_error;
  } baud_pick_t;

  localparam int DIV_LIMIT  = 8191;
  localparam int PIPE_DEPTH = 100;
  localparam int CYCLE_CAP  = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ubds_cfg_if cfg_ch ();
  ubds_req_if req_ch ();
  ubds_res_if res_ch ();

  uart_baud_divisor_search #(.DIVISOR_MAX(DIV_LIMIT)) dut (
    .clk(clk), .rst(rst), .cfg(cfg_ch.sink), .req(req_ch.sink),
    .res(res_ch.source)
  );

  logic [31:0]  src_clock_hz;
  logic [23:0]  pending_bauds[$];
  baud_pick_t   expected_picks[$];
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_off_cycles = 0;
  int           fail_count = 0;
  int           cycle_count = 0;

  // Search ratios 4..32 for the best divisor under the current clock.
  function automatic baud_pick_t pick_divisor(logic [23:0] baud, logic [31:0] clk_hz);
    baud_pick_t  best;
    logic [31:0] dv;
    logic [31:0] actual;
    logic [31:0] err;
    best.divisor = '0;
    best.oversample_field = ubds_pkg::NONE_FIELD;
    best.found = 1'b0;
    best.baud_error = ubds_pkg::NONE_ERROR;
    if (baud != 0) begin
      for (int r = ubds_pkg::RATIO_MIN; r <= ubds_pkg::RATIO_MAX; r++) begin
        dv = clk_hz / (32'(baud) * 32'(r));
        if (dv >= 1 && dv <= DIV_LIMIT) begin
          actual = clk_hz / (32'(r) * dv);
          err = (actual >= baud) ? actual - baud : 32'(baud) - actual;
          if (err < best.baud_error) begin
            best.baud_error = err;
            best.divisor = dv[12:0];
            best.oversample_field = 5'(r - 1);
            best.found = 1'b1;
          end
        end
      end
    end
    return best;
  endfunction

  // Clock generator.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer queued items; the predictor runs at acceptance.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.requested_baud <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_picks.push_back(pick_divisor(req_ch.requested_baud, src_clock_hz));
        void'(pending_bauds.pop_front());
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_bauds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_ch.valid <= 1'b1;
          req_ch.requested_baud <= pending_bauds[0];
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Count down the long receiver hold-off.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
    end
  end

  // Check results in order and drive ready.
  always @(posedge clk) begin
    baud_pick_t got;
    baud_pick_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.divisor, res_ch.oversample_field, res_ch.found, res_ch.baud_error};
        if (expected_picks.size() == 0) begin
          $error("unexpected result item");
          fail_count++;
        end else begin
          want = expected_picks.pop_front();
          if (got.divisor !== want.divisor) begin
            $error("divisor: expected %0d got %0d", want.divisor, got.divisor);
            fail_count++;
          end
          if (got.oversample_field !== want.oversample_field) begin
            $error("oversample_field: expected %0d got %0d", want.oversample_field,
                   got.oversample_field);
            fail_count++;
          end
          if (got.found !== want.found) begin
            $error("found: expected %0d got %0d", want.found, got.found);
            fail_count++;
          end
          if (got.baud_error !== want.baud_error) begin
            $error("baud_error: expected %0d got %0d", want.baud_error, got.baud_error);
            fail_count++;
          end
        end
      end
      if (hold_off_cycles > 0) begin
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Bound the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("[uart_baud_divisor_search] ERROR");
      $finish;
    end
  end

  // Write the clock register while idle.
  task automatic write_clock(logic [31:0] hz);
    cfg_ch.valid <= 1'b1;
    cfg_ch.source_clock_hz <= hz;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    src_clock_hz = hz;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every queued item went in and every result came out.
  task automatic drain();
    while (pending_bauds.size() > 0 || req_ch.valid || expected_picks.size() > 0)
      @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  // Mostly realistic rates, some small, some wide, a few zeros.
  function automatic logic [23:0] random_baud();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) return 24'($urandom_range(300, 4000000));
    else if (sel < 6) return 24'($urandom_range(1, 2000));
    else if (sel < 8) return 24'($urandom);
    else if (sel == 8) return 24'd0;
    else return 24'($urandom_range(9600, 115200));
  endfunction

  task automatic random_batch(int n);
    for (int i = 0; i < n; i++) pending_bauds.push_back(random_baud());
  endtask

  initial begin
    logic [31:0] clocks[5];
    cfg_ch.valid = 1'b0;
    cfg_ch.source_clock_hz = '0;
    req_ch.valid = 1'b0;
    req_ch.requested_baud = '0;
    res_ch.ready = 1'b0;
    src_clock_hz = ubds_pkg::CLK_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset clock, zero baud, extremes, common rates.
    pending_bauds = '{24'd0, 24'd1, 24'hFFFFFF, 24'h800000, 24'd9600, 24'd115200,
                      24'd3000000, 24'd12000000, 24'd1500000, 24'd300, 24'd2,
                      24'h555555, 24'hAAAAAA, 24'd366, 24'd367};
    drain();

    // Zero clock, then all-ones clock.
    write_clock(32'd0);
    pending_bauds = '{24'd9600, 24'd1, 24'hFFFFFF};
    drain();
    write_clock(32'hFFFF_FFFF);
    pending_bauds = '{24'd1, 24'd9600, 24'hFFFFFF, 24'd16390, 24'd0};
    drain();

    clocks = '{32'd48000000, 32'd8000000, 32'hFFFF_FFFF, 32'd0, 32'd160000000};
    for (int ph = 0; ph < 5; ph++) begin
      write_clock(ph == 3 ? 32'($urandom) : clocks[ph]);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        3: begin send_idle_pct = 30; recv_stall_pct = 30; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (ph == 4) hold_off_cycles = 300;
      random_batch(ph == 4 ? 160 : 60);
      drain();
    end
    if (fail_count == 0) begin
      $display("[uart_baud_divisor_search] OK");
    end else begin
      $display("[uart_baud_divisor_search] ERROR");
    end
    $finish;
  end

endmodule
